FILE: hdl/disk_block_to_chs_translator_core_macros.svh
// assertion macros used by the translator top level
// no dependencies
`ifndef DISK_BLOCK_TO_CHS_TRANSLATOR_CORE_MACROS_SVH
`define DISK_BLOCK_TO_CHS_TRANSLATOR_CORE_MACROS_SVH
// property checked every clock edge outside reset
`define DB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check that also holds during reset
`define DB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

FILE: hdl/dbchs_pkg.sv
// types and constants for the block to cylinder/head/sector translator
// used by every module in hdl
package dbchs_pkg;
  localparam int SLICE_COUNT  = 16;
  localparam int SLICE_W      = 4;
  localparam int SECTOR_SHIFT = 9;
  localparam int BLOCK_W      = 31;
  localparam int SUM_W        = 32;
  localparam int SPC_W        = 16;
  localparam int BYTES_W      = 25;
  localparam int CYL_W        = 16;
  localparam int CNT_W        = 16;
  localparam int NUM_CELLS    = SUM_W + 1;

  localparam logic [7:0] REG_SPT   = 8'd0;
  localparam logic [7:0] REG_HEADS = 8'd1;
  localparam logic [0:0] ACT_TRANSLATE = 1'b0;
  localparam logic [0:0] ACT_LOAD      = 1'b1;

  // word carried down the divider chain
  typedef struct packed {
    logic                  vld;
    logic [1:0]            unit;
    logic                  rd;
    logic [CNT_W-1:0]      cnt;
    logic [SUM_W-1:0]      quo;   // quotient bits shift in, dividend bits shift out
    logic [SPC_W:0]        rem;   // partial remainder
    logic [SPC_W-1:0]      spc;
    logic [7:0]            spt;
    logic [2:0]            phase; // 0: cylinder divide, 1: head divide
  } dbchs_word_t;
endpackage

FILE: hdl/dbchs_cell.sv
// one restoring-division step: shifts in one dividend bit and decides one quotient bit
// depends on dbchs_pkg
module dbchs_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               stall,
  input  dbchs_pkg::dbchs_word_t d_in,
  output dbchs_pkg::dbchs_word_t d_out
);
  dbchs_pkg::dbchs_word_t word_r, word_nxt;
  logic [dbchs_pkg::SPC_W+1:0] trial;

  always_comb begin
    word_nxt = d_in;
    trial = {d_in.rem, d_in.quo[dbchs_pkg::SUM_W-1]} - {2'b00, d_in.spc};
    word_nxt.quo = {d_in.quo[dbchs_pkg::SUM_W-2:0], ~trial[dbchs_pkg::SPC_W+1]};
    if (trial[dbchs_pkg::SPC_W+1]) begin
      word_nxt.rem = {d_in.rem[dbchs_pkg::SPC_W-1:0], d_in.quo[dbchs_pkg::SUM_W-1]};
    end else begin
      word_nxt.rem = trial[dbchs_pkg::SPC_W:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.vld <= 1'b0;
    end else if (!stall) begin
      word_r <= word_nxt;
    end
  end

  assign d_out = word_r;
endmodule

FILE: hdl/dbchs_front.sv
// slice table, base add, geometry and sector count rounding
// depends on dbchs_pkg
module dbchs_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          stall,
  input  logic                          take,
  input  logic                          action,
  input  logic [1:0]                    drive_unit,
  input  logic [3:0]                    slice_index,
  input  logic [dbchs_pkg::BLOCK_W-1:0] block_number,
  input  logic [dbchs_pkg::BYTES_W-1:0] byte_count,
  input  logic                          is_read,
  input  logic [dbchs_pkg::BLOCK_W-1:0] base_value,
  input  logic [7:0]                    spt_reg,
  input  logic [7:0]                    heads_reg,
  output dbchs_pkg::dbchs_word_t        d_out
);
  logic [dbchs_pkg::BLOCK_W-1:0] table_r [dbchs_pkg::SLICE_COUNT];
  logic [dbchs_pkg::BLOCK_W-1:0] base;
  logic [7:0] spt, hpc;
  logic [dbchs_pkg::BYTES_W:0] cnt_sum;
  logic [dbchs_pkg::BYTES_W-dbchs_pkg::SECTOR_SHIFT:0] cnt_full;
  dbchs_pkg::dbchs_word_t word_r, word_nxt;

  always_ff @(posedge clk) begin
    if (take && action == dbchs_pkg::ACT_LOAD) begin
      table_r[slice_index] <= base_value;
    end
  end

  always_comb begin
    base = table_r[slice_index];
    spt = (spt_reg == 8'd0) ? 8'd1 : spt_reg;
    hpc = (heads_reg == 8'd0) ? 8'd1 : heads_reg;
    cnt_sum = {1'b0, byte_count} + ((dbchs_pkg::BYTES_W+1)'(1) << dbchs_pkg::SECTOR_SHIFT)
              - (dbchs_pkg::BYTES_W+1)'(1);
    cnt_full = cnt_sum[dbchs_pkg::BYTES_W:dbchs_pkg::SECTOR_SHIFT];
    word_nxt.vld = take && action == dbchs_pkg::ACT_TRANSLATE;
    word_nxt.unit = drive_unit;
    word_nxt.rd = is_read;
    word_nxt.cnt = (cnt_full > (dbchs_pkg::BYTES_W-dbchs_pkg::SECTOR_SHIFT+1)'(16'hFFFF))
                   ? 16'hFFFF : cnt_full[dbchs_pkg::CNT_W-1:0];
    word_nxt.quo = {1'b0, block_number} + {1'b0, base};
    word_nxt.rem = '0;
    word_nxt.spc = {8'h00, spt} * {8'h00, hpc};
    word_nxt.spt = spt;
    word_nxt.phase = 3'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.vld <= 1'b0;
    end else if (!stall) begin
      word_r <= word_nxt;
    end
  end

  assign d_out = word_r;
endmodule

FILE: hdl/dbchs_split.sv
// turns cylinder quotient and remainder into the head/sector divide and the result word
// depends on dbchs_pkg; the head divide runs as 16 more cells
module dbchs_split (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   stall,
  input  dbchs_pkg::dbchs_word_t cyl_in,
  output dbchs_pkg::dbchs_word_t head_in,
  input  dbchs_pkg::dbchs_word_t head_out,
  output logic                   res_vld,
  output logic [1:0]             res_unit,
  output logic [15:0]            res_cyl,
  output logic [7:0]             res_head,
  output logic [7:0]             res_sec,
  output logic [15:0]            res_cnt,
  output logic                   res_rd,
  output logic                   res_oor
);
  // cylinder and flag travel on a side line beside the head cells
  dbchs_pkg::dbchs_word_t word_r, word_nxt;
  logic [15:0] cyl_r;
  logic        oor_r;
  logic [15:0] cyl_q [16];
  logic        oor_q [16];
  logic        sat;

  always_comb begin
    sat = |cyl_in.quo[31:16];
    word_nxt = cyl_in;
    word_nxt.quo = {cyl_in.rem[15:0], 16'h0000};
    word_nxt.rem = '0;
    word_nxt.spc = {8'h00, cyl_in.spt};
    word_nxt.phase = 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r.vld <= 1'b0;
    end else if (!stall) begin
      word_r <= word_nxt;
      cyl_r <= sat ? 16'hFFFF : cyl_in.quo[15:0];
      oor_r <= sat;
    end
  end

  assign head_in = word_r;

  // side line that keeps cylinder alongside the head cells
  always_ff @(posedge clk) begin
    if (!stall) begin
      cyl_q[0] <= cyl_r;
      oor_q[0] <= oor_r;
      for (int i = 1; i < 16; i++) begin
        cyl_q[i] <= cyl_q[i-1];
        oor_q[i] <= oor_q[i-1];
      end
    end
  end

  // after 16 shifts the head quotient sits in the low quo bits
  assign res_vld  = head_out.vld;
  assign res_unit = head_out.unit;
  assign res_cyl  = cyl_q[15];
  assign res_oor  = oor_q[15];
  assign res_head = head_out.quo[7:0];
  assign res_sec  = head_out.rem[7:0];
  assign res_cnt  = head_out.cnt;
  assign res_rd   = head_out.rd;
endmodule

FILE: hdl/disk_block_to_chs_translator_core.sv
// Block to cylinder/head/sector translator, top level.
// Channels: in_* (valid/ready) carries load and translate words; out_* carries one
// result word per translate word, none for a load word. cfg_* writes register 0
// (sectors per track) and register 1 (heads per cylinder); other indexes are ignored.
// A load word writes a slice table entry in the cycle it is accepted.
// The word passes one front stage (loaded at the accepting edge), 32 cells of
// the cylinder divide, one split stage, 16 cells of the head divide and one
// output register. Throughput: one word per cycle while the receiver takes
// results; each divide cell retires one quotient bit.
// When the receiver stalls, the whole chain holds and in_ready drops while the
// output register is full and not taken.
// Reset clears the pipeline valid bits and sets geometry to 64 sectors, 1 head;
// slice entries are undefined until loaded. cfg_ready is always high.
`include "disk_block_to_chs_translator_core_macros.svh"
module disk_block_to_chs_translator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [1:0]  in_drive_unit,
  input  logic [3:0]  in_slice_index,
  input  logic [30:0] in_block_number,
  input  logic [24:0] in_byte_count,
  input  logic        in_is_read,
  input  logic [30:0] in_base_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_unit_out,
  output logic [15:0] out_cylinder,
  output logic [7:0]  out_head_number,
  output logic [7:0]  out_sector_number,
  output logic [15:0] out_sector_count,
  output logic        out_read_command,
  output logic        out_out_of_range,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  logic [7:0] spt_r, heads_r;
  logic stall, take;
  dbchs_pkg::dbchs_word_t chain_a [dbchs_pkg::NUM_CELLS];
  dbchs_pkg::dbchs_word_t chain_b [17];
  logic        res_vld, res_rd, res_oor;
  logic [1:0]  res_unit;
  logic [15:0] res_cyl, res_cnt;
  logic [7:0]  res_head, res_sec;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r <= 8'd64;
      heads_r <= 8'd1;
    end else if (cfg_valid) begin
      if (cfg_index == dbchs_pkg::REG_SPT) spt_r <= cfg_data;
      if (cfg_index == dbchs_pkg::REG_HEADS) heads_r <= cfg_data;
    end
  end

  assign stall = out_valid && !out_ready;
  assign in_ready = !stall;
  assign take = in_valid && in_ready;

  dbchs_front u_front (
    .clk(clk), .rst_n(rst_n), .stall(stall), .take(take),
    .action(in_action), .drive_unit(in_drive_unit), .slice_index(in_slice_index),
    .block_number(in_block_number), .byte_count(in_byte_count), .is_read(in_is_read),
    .base_value(in_base_value), .spt_reg(spt_r), .heads_reg(heads_r),
    .d_out(chain_a[0])
  );

  for (genvar g = 0; g < dbchs_pkg::SUM_W; g++) begin : g_cyl
    dbchs_cell u_cell (
      .clk(clk), .rst_n(rst_n), .stall(stall), .d_in(chain_a[g]), .d_out(chain_a[g+1])
    );
  end

  dbchs_split u_split (
    .clk(clk), .rst_n(rst_n), .stall(stall), .cyl_in(chain_a[dbchs_pkg::SUM_W]),
    .head_in(chain_b[0]), .head_out(chain_b[16]),
    .res_vld(res_vld), .res_unit(res_unit), .res_cyl(res_cyl), .res_head(res_head),
    .res_sec(res_sec), .res_cnt(res_cnt), .res_rd(res_rd), .res_oor(res_oor)
  );

  for (genvar g = 0; g < 16; g++) begin : g_head
    dbchs_cell u_cell (
      .clk(clk), .rst_n(rst_n), .stall(stall), .d_in(chain_b[g]), .d_out(chain_b[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (!stall) begin
      out_valid <= res_vld;
      out_unit_out <= res_unit;
      out_cylinder <= res_cyl;
      out_head_number <= res_head;
      out_sector_number <= res_sec;
      out_sector_count <= res_cnt;
      out_read_command <= res_rd;
      out_out_of_range <= res_oor;
    end
  end

  `DB_ASSERT(a_stall_holds, stall |=> out_valid, "stalled word vanished")
  `DB_ASSERT(a_ready_follows, in_ready == !(out_valid && !out_ready), "ready mismatch")
  `DB_ASSERT(a_sat_flag, out_valid && out_out_of_range |-> out_cylinder == 16'hFFFF,
             "saturated cylinder not at maximum")
  `DB_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "output valid after reset")
endmodule

FILE: sim/disk_block_to_chs_translator_core_tb.sv
// self-checking testbench for the block to cylinder/head/sector translator
// depends on dbchs_pkg and disk_block_to_chs_translator_core from hdl
`timescale 1ns / 1ps
module disk_block_to_chs_translator_core_tb;

  localparam int LATENCY    = 50;
  localparam int WATCHDOG   = 20000;
  localparam int RAND_ITEMS = 600;
  localparam logic [7:0] REG_BAD = 8'd7;

  typedef struct packed {
    logic [0:0]  action;
    logic [1:0]  unit;
    logic [3:0]  slice;
    logic [30:0] block;
    logic [24:0] bytes;
    logic        rd;
    logic [30:0] base;
  } req_t;

  typedef struct packed {
    logic [1:0]  unit;
    logic [15:0] cyl;
    logic [7:0]  head;
    logic [7:0]  sect;
    logic [15:0] cnt;
    logic        rd;
    logic        oor;
  } chs_t;

  typedef struct {
    req_t req;
    logic typed;   // expected result given in the table
    chs_t chs;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [0:0] in_action = '0;
  logic [1:0] in_drive_unit = '0;
  logic [3:0] in_slice_index = '0;
  logic [30:0] in_block_number = '0;
  logic [24:0] in_byte_count = '0;
  logic in_is_read = 1'b0;
  logic [30:0] in_base_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_unit_out;
  logic [15:0] out_cylinder;
  logic [7:0] out_head_number, out_sector_number;
  logic [15:0] out_sector_count;
  logic out_read_command, out_out_of_range;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  disk_block_to_chs_translator_core dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor copy of the geometry and slice table
  logic [7:0]  spt_q, heads_q;
  logic [30:0] slice_base[dbchs_pkg::SLICE_COUNT];
  chs_t        chs_pending[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;

  function automatic chs_t translate_chs(req_t r);
    chs_t c;
    logic [31:0] lba, cyl, rem;
    logic [15:0] spc;
    logic [7:0] spt, hd;
    logic [25:0] cnt;
    spt = (spt_q == 0) ? 8'd1 : spt_q;
    hd  = (heads_q == 0) ? 8'd1 : heads_q;
    spc = spt * hd;
    lba = {1'b0, r.block} + {1'b0, slice_base[r.slice]};
    cyl = lba / spc;
    rem = lba % spc;
    cnt = ({1'b0, r.bytes} + 26'd511) >> dbchs_pkg::SECTOR_SHIFT;
    c.unit = r.unit;
    c.oor  = cyl > 32'd65535;
    c.cyl  = c.oor ? 16'hFFFF : cyl[15:0];
    c.head = 8'(rem / spt);
    c.sect = 8'(rem % spt);
    c.cnt  = (cnt > 26'd65535) ? 16'hFFFF : cnt[15:0];
    c.rd   = r.rd;
    return c;
  endfunction

  always @(posedge clk) begin
    if (rst_n && (in_valid && in_ready || out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG);
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: random stalls, compare against oldest expectation
  always @(posedge clk) begin
    chs_t got, exp_c;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_unit_out, out_cylinder, out_head_number, out_sector_number,
              out_sector_count, out_read_command, out_out_of_range};
      results_seen <= results_seen + 1;
      if (chs_pending.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected word %p", got);
      end else begin
        exp_c = chs_pending.pop_front();
        if (got !== exp_c) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("mismatch: expected %p got %p", exp_c, got);
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (calm) out_ready <= 1'b1;
    else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(1, 12) - 1;
    end else out_ready <= 1'b1;
  end

  task automatic write_reg(logic [7:0] idx, logic [7:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == dbchs_pkg::REG_SPT) spt_q = val;
    else if (idx == dbchs_pkg::REG_HEADS) heads_q = val;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (chs_pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // valid stays high between back to back words; it drops only for an idle burst or while draining
  task automatic send_req(req_t r, logic typed, chs_t c);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_action <= r.action; in_drive_unit <= r.unit; in_slice_index <= r.slice;
    in_block_number <= r.block; in_byte_count <= r.bytes; in_is_read <= r.rd;
    in_base_value <= r.base;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (r.action == dbchs_pkg::ACT_LOAD) begin
      slice_base[r.slice] = r.base;
    end else chs_pending.push_back(typed ? c : translate_chs(r));
  endtask

  function automatic req_t rand_req(bit load_ok);
    req_t r;
    r.action = (load_ok && $urandom_range(0, 5) == 0) ? dbchs_pkg::ACT_LOAD
                                                      : dbchs_pkg::ACT_TRANSLATE;
    r.unit = 2'($urandom_range(0, 3));
    r.slice = 4'($urandom_range(0, dbchs_pkg::SLICE_COUNT - 1));
    case ($urandom_range(0, 3))
      0: r.block = 31'($urandom_range(0, 4095));
      1: r.block = 31'(32'h7FFFFFFF - $urandom_range(0, 15));
      default: r.block = 31'($urandom);
    endcase
    r.bytes = ($urandom_range(0, 3) == 0) ? 25'(32'h1FFFFFF - $urandom_range(0, 600))
                                          : 25'($urandom_range(0, 70000));
    if ($urandom_range(0, 3) == 0) r.bytes = 25'($urandom);
    r.rd = 1'($urandom);
    r.base = ($urandom_range(0, 2) == 0) ? 31'($urandom_range(0, 100000)) : 31'($urandom);
    return r;
  endfunction

  row_t dir_rows[$];
  initial begin
    req_t r;
    chs_t none;
    logic [7:0] geo[6][2] = '{'{8'd64, 8'd1}, '{8'd1, 8'd1}, '{8'd255, 8'd255},
                             '{8'd0, 8'd0}, '{8'd63, 8'd16}, '{8'd17, 8'd4}};
    none = '0;
    spt_q = 8'd64;
    heads_q = 8'd1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // load every slice first so no translate reads an unwritten entry
    for (int s = 0; s < dbchs_pkg::SLICE_COUNT; s++) begin
      r = '0; r.action = dbchs_pkg::ACT_LOAD; r.slice = 4'(s);
      r.base = (s == 15) ? 31'h7FFFFFFF : (s == 0 ? 31'd0 : 31'(s * 1000));
      dir_rows.push_back('{r, 1'b0, none});
    end
    // reset geometry: 64 sectors, 1 head, slice 0 base zero
    r = '0; r.block = 31'd130; r.bytes = 25'd513; r.rd = 1'b1; r.unit = 2'd3;
    dir_rows.push_back('{r, 1'b1, '{2'd3, 16'd2, 8'd0, 8'd2, 16'd2, 1'b1, 1'b0}});
    r = '0; r.bytes = 25'd0;
    dir_rows.push_back('{r, 1'b1, '{2'd0, 16'd0, 8'd0, 8'd0, 16'd0, 1'b0, 1'b0}});
    // byte count saturates, cylinder saturates with max block and max base
    r = '0; r.slice = 4'd15; r.block = 31'h7FFFFFFF; r.bytes = 25'h1FFFFFF;
    r.unit = 2'd1;
    dir_rows.push_back('{r, 1'b0, none});
    r = '0; r.block = 31'h7FFFFFFF; r.bytes = 25'd512; r.rd = 1'b1;
    dir_rows.push_back('{r, 1'b1, '{2'd0, 16'hFFFF, 8'd0, 8'd63, 16'd1, 1'b1, 1'b1}});
    r = '0; r.block = 31'(65535 * 64 + 63); r.bytes = 25'd1;
    dir_rows.push_back('{r, 1'b1, '{2'd0, 16'hFFFF, 8'd0, 8'd63, 16'd1, 1'b0, 1'b0}});
    r = '0; r.block = 31'(65536 * 64); r.bytes = 25'd33553920;
    dir_rows.push_back('{r, 1'b1, '{2'd0, 16'hFFFF, 8'd0, 8'd0, 16'hFFFF, 1'b0, 1'b1}});
    r = '0; r.slice = 4'd7; r.block = 31'd77; r.bytes = 25'd1000; r.unit = 2'd2;
    dir_rows.push_back('{r, 1'b0, none});

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].chs);
    wait_drained();
    write_reg(REG_BAD, 8'd3);

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(dbchs_pkg::REG_SPT, geo[ph][0]);
      write_reg(dbchs_pkg::REG_HEADS, geo[ph][1]);
      if (ph == 5) calm = 1'b1;
      for (int n = 0; n < RAND_ITEMS / 6; n++) send_req(rand_req(1'b1), 1'b0, none);
      wait_drained();
    end

    $display("covered %0d results over six geometries incl. zero and 255x255,",
             results_seen);
    $display("slice loads, cylinder and sector count saturation");
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
